// ===== rtl/core/mtdxf_pkg.sv =====
// Shared constants and types for the multi-tap delay send with crossfade.
// No dependencies; every other file in rtl/core except mtdxf_ram imports this package.
`timescale 1ns / 1ps

package mtdxf_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int RING_LENGTH_DEF = 4096;
    localparam int TAP_COUNT_DEF   = 4;

    // Fixed field widths.
    localparam int SAMPLE_W    = 16;
    localparam int DELAY_W     = 12;
    localparam int GAIN_W      = 16;
    localparam int SEND_W      = 18;
    localparam int BLEND_W     = 11;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 28;

    // Tap register layout.
    localparam int GAIN_LSB = 12;

    // Blend arithmetic.
    localparam logic [BLEND_W-1:0] BLEND_ONE = 11'd1024;
    localparam int BLEND_SHIFT = 10;

    // Rounding of the crossfade result and reciprocal precision for the delay wrap.
    localparam int ROUND_SHIFT = 24;
    localparam int RECIP_SHIFT = 24;

    // Saturation limits of the send output.
    localparam int SEND_MAX = 131071;
    localparam int SEND_MIN = -131072;

    // Request from the sequencer to the crossfade unit.
    typedef struct packed {
        logic               start;
        logic [BLEND_W-1:0] used;
    } mix_req_t;

    // Answer from the crossfade unit.
    typedef struct packed {
        logic                     done;
        logic signed [SEND_W-1:0] send;
    } mix_res_t;

endpackage

// ===== rtl/core/mtdxf_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing; used for the sample history ring.
`timescale 1ns / 1ps

module mtdxf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One access per cycle: a write, or a read whose data shows up next cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/mtdxf_tap_addr.sv =====
// Turns one tap register into a ring address, a gain and a written flag.
// Depends on mtdxf_pkg for the tap layout and the reciprocal precision.
`timescale 1ns / 1ps

module mtdxf_tap_addr #(
    parameter int RING_LENGTH = mtdxf_pkg::RING_LENGTH_DEF
) (
    input  logic [mtdxf_pkg::CFG_DATA_W-1:0]    tap,
    input  logic [$clog2(RING_LENGTH)-1:0]      wp,
    input  logic                                wrapped,
    output logic [$clog2(RING_LENGTH)-1:0]      addr,
    output logic signed [mtdxf_pkg::GAIN_W-1:0] gain,
    output logic                                written
);

    import mtdxf_pkg::*;

    localparam int AW     = $clog2(RING_LENGTH);
    localparam int RW     = AW + 1;
    localparam int QP_W   = DELAY_W + RECIP_SHIFT;
    localparam int RECIP  = (1 << RECIP_SHIFT) / RING_LENGTH;

    logic [DELAY_W-1:0] delay;
    logic [QP_W-1:0]    qprod;
    logic [DELAY_W-1:0] quot;
    logic [31:0]        rem0;
    logic [RW-1:0]      dmod;
    logic [RW-1:0]      wp_ext;
    logic [RW-1:0]      diff;

    assign delay = tap[DELAY_W-1:0];
    assign gain  = signed'(tap[GAIN_LSB +: GAIN_W]);

    // Delay modulo the ring length: reciprocal estimate, low by at most one,
    // then a single corrective subtract.
    always_comb
    begin
        qprod = QP_W'(delay) * QP_W'(RECIP);
        quot  = DELAY_W'(qprod >> RECIP_SHIFT);
        rem0  = 32'(delay) - 32'(quot) * 32'(RING_LENGTH);
        if (rem0 >= 32'(RING_LENGTH))
        begin
            dmod = RW'(rem0 - 32'(RING_LENGTH));
        end
        else
        begin
            dmod = RW'(rem0);
        end
    end

    // Step back from the write position, wrapping below zero.
    always_comb
    begin
        wp_ext = {1'b0, wp};
        if (wp_ext >= dmod)
        begin
            diff = wp_ext - dmod;
        end
        else
        begin
            diff = wp_ext + RW'(RING_LENGTH) - dmod;
        end
    end

    assign addr = diff[AW-1:0];

    // Entries past the fill point have never been written; they are read as zero.
    assign written = wrapped || (addr <= wp);

endmodule

// ===== rtl/core/mtdxf_mix.sv =====
// Crossfade of the two tap sums with round-half-up and 18-bit saturation.
// Depends on mtdxf_pkg for the request and answer structs.
`timescale 1ns / 1ps

module mtdxf_mix #(
    parameter int SUM_W = 34
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mtdxf_pkg::mix_req_t      req,
    input  logic signed [SUM_W-1:0]  old_sum,
    input  logic signed [SUM_W-1:0]  new_sum,
    output mtdxf_pkg::mix_res_t      res
);

    import mtdxf_pkg::*;

    localparam int DIFF_W = SUM_W + 1;
    localparam int PROD_W = DIFF_W + BLEND_W + 1;
    localparam int MIX_W  = PROD_W + 1;

    localparam logic signed [MIX_W-1:0] HALF = MIX_W'(1) <<< (ROUND_SHIFT - 1);
    localparam logic signed [MIX_W-1:0] LIM_HI = MIX_W'(SEND_MAX);
    localparam logic signed [MIX_W-1:0] LIM_LO = MIX_W'(SEND_MIN);

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [MIX_W-1:0]  base_reg;
    logic                     s1_valid_reg;
    logic signed [MIX_W-1:0]  mix;
    logic signed [MIX_W-1:0]  shifted;
    logic signed [SEND_W-1:0] send_next;
    logic signed [SEND_W-1:0] send_reg;
    logic                     done_reg;

    // First stage: (new - old) * blend, and old scaled by one full blend.
    always_comb
    begin
        diff      = DIFF_W'(new_sum) - DIFF_W'(old_sum);
        prod_next = PROD_W'(diff) * PROD_W'(signed'({1'b0, req.used}));
    end

    // Second stage: add, round half up, saturate.
    always_comb
    begin
        mix     = MIX_W'(prod_reg) + base_reg + HALF;
        shifted = mix >>> ROUND_SHIFT;
        if (shifted > LIM_HI)
        begin
            send_next = SEND_W'(LIM_HI);
        end
        else if (shifted < LIM_LO)
        begin
            send_next = SEND_W'(LIM_LO);
        end
        else
        begin
            send_next = SEND_W'(shifted);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req.start;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            prod_reg <= prod_next;
            base_reg <= MIX_W'(old_sum) <<< BLEND_SHIFT;
        end
        if (s1_valid_reg)
        begin
            send_reg <= send_next;
        end
    end

    assign res.done = done_reg;
    assign res.send = send_reg;

    // A result appears once its request has passed through s1_valid_reg and then done_reg.
    a_done_timing: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(req.start, 2))
        else $error("crossfade result without a request two cycles earlier");

endmodule

// ===== rtl/core/multitap_delay_send_crossfade_unit.sv =====
// Top level: sequencer, tap registers, ring memory, tap multiply-accumulate.
// Depends on mtdxf_pkg, mtdxf_ram, mtdxf_tap_addr and mtdxf_mix.
//
//  channel   direction  handshake              beat contents
//  in        sink       in_valid / in_stall    sample, fade_on, fade_restart
//  out       source     out_valid / out_stall  send, blend_level, fade_done
//  cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// For each input beat, one write and 2*TAP_COUNT tap reads share the single port
// of the ring memory; then the multiply pipeline drains, the crossfade unit does
// its arithmetic, the output register is loaded and the sequencer returns to idle
// to take the next beat.
// After reset the ring reads as zeros through a fill pointer; no clearing pass.
// A finished result waits in the output register while the next beat is taken;
// a result still stalled there holds the sequencer in its last step.
`timescale 1ns / 1ps

module multitap_delay_send_crossfade_unit #(
    parameter int RING_LENGTH = mtdxf_pkg::RING_LENGTH_DEF,
    parameter int TAP_COUNT   = mtdxf_pkg::TAP_COUNT_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [mtdxf_pkg::SAMPLE_W-1:0] sample,
    input  logic                                  fade_on,
    input  logic                                  fade_restart,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [mtdxf_pkg::SEND_W-1:0]   send,
    output logic [mtdxf_pkg::BLEND_W-1:0]         blend_level,
    output logic                                  fade_done,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mtdxf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mtdxf_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import mtdxf_pkg::*;

    localparam int AW      = $clog2(RING_LENGTH);
    localparam int NREG    = 2 * TAP_COUNT;
    localparam int CNT_W   = $clog2(NREG);
    localparam int TPROD_W = SAMPLE_W + GAIN_W;
    localparam int SUM_W   = TPROD_W + $clog2(TAP_COUNT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_DRAIN,
        S_MIX,
        S_PUSH
    } state_t;

    state_t state_reg;

    // Tap registers and per-beat state.
    logic [CFG_DATA_W-1:0]      tap_reg [NREG];
    logic [AW-1:0]              wp_reg;
    logic                       wrapped_reg;
    logic [BLEND_W-1:0]         blend_reg;
    logic [BLEND_W-1:0]         blend_next;
    logic [BLEND_W-1:0]         used_reg;
    logic [BLEND_W-1:0]         used_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       on_reg;
    logic                       restart_reg;
    logic [CNT_W-1:0]           cnt_reg;

    // Tap pipeline.
    logic                       p1_valid_reg;
    logic                       p1_new_reg;
    logic                       p1_written_reg;
    logic signed [GAIN_W-1:0]   p1_gain_reg;
    logic                       p2_valid_reg;
    logic                       p2_new_reg;
    logic signed [TPROD_W-1:0]  prod_reg;
    logic signed [SUM_W-1:0]    acc_old_reg;
    logic signed [SUM_W-1:0]    acc_new_reg;

    // Output register.
    logic                       out_valid_reg;
    logic signed [SEND_W-1:0]   send_reg;
    logic [BLEND_W-1:0]         blend_level_reg;
    logic                       fade_done_reg;

    // Ring and helpers.
    logic                       ram_we;
    logic [AW-1:0]              ram_addr;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic [AW-1:0]              tap_addr;
    logic signed [GAIN_W-1:0]   tap_gain;
    logic                       tap_written;
    logic signed [SAMPLE_W-1:0] rd_sample;
    logic signed [SUM_W-1:0]    new_sum;
    logic                       pipe_empty;
    logic                       out_free;
    mix_req_t                   mix_req;
    mix_res_t                   mix_res;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // Address of the tap under issue.
    mtdxf_tap_addr #(
        .RING_LENGTH (RING_LENGTH)
    ) u_tap_addr (
        .tap     (tap_reg[cnt_reg]),
        .wp      (wp_reg),
        .wrapped (wrapped_reg),
        .addr    (tap_addr),
        .gain    (tap_gain),
        .written (tap_written)
    );

    // The ring takes the new sample first, then serves the tap reads.
    assign ram_we   = (state_reg == S_WRITE);
    assign ram_addr = ram_we ? wp_reg : tap_addr;

    mtdxf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_LENGTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (sample_reg),
        .rdata (ram_rdata)
    );

    // Blend update for this beat.
    always_comb
    begin
        blend_next = restart_reg ? '0 : blend_reg;
        if (on_reg)
        begin
            blend_next = (blend_next < BLEND_ONE) ? blend_next + 1'b1 : BLEND_ONE;
        end
        used_next = on_reg ? blend_next : '0;
    end

    assign rd_sample  = p1_written_reg ? signed'(ram_rdata) : '0;
    assign new_sum    = on_reg ? acc_new_reg : '0;
    assign pipe_empty = !p1_valid_reg && !p2_valid_reg;
    assign out_free   = !out_valid_reg || !out_stall;

    assign mix_req.start = (state_reg == S_DRAIN) && pipe_empty;
    assign mix_req.used  = used_reg;

    mtdxf_mix #(
        .SUM_W (SUM_W)
    ) u_mix (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mix_req),
        .old_sum (acc_old_reg),
        .new_sum (new_sum),
        .res     (mix_res)
    );

    // Sequencer, tap registers, pipeline control and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int i = 0; i < NREG; i++)
            begin
                tap_reg[i] <= '0;
            end
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            blend_reg     <= '0;
            cnt_reg       <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && (int'(cfg_index) < NREG))
            begin
                tap_reg[cfg_index[CNT_W-1:0]] <= cfg_data;
            end

            // The output register refills from the last step or empties when taken.
            if (state_reg == S_PUSH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            p1_valid_reg <= (state_reg == S_READ);
            p2_valid_reg <= p1_valid_reg;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    blend_reg <= blend_next;
                    cnt_reg   <= '0;
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    if (cnt_reg == CNT_W'(NREG - 1))
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    if (pipe_empty)
                    begin
                        state_reg <= S_MIX;
                    end
                end
                S_MIX:
                begin
                    if (mix_res.done)
                    begin
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    if (out_free)
                    begin
                        if (wp_reg == AW'(RING_LENGTH - 1))
                        begin
                            wp_reg      <= '0;
                            wrapped_reg <= 1'b1;
                        end
                        else
                        begin
                            wp_reg <= wp_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers of the beat, the tap pipeline and the output.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            sample_reg  <= sample;
            on_reg      <= fade_on;
            restart_reg <= fade_restart;
        end
        if (state_reg == S_WRITE)
        begin
            used_reg    <= used_next;
            acc_old_reg <= '0;
            acc_new_reg <= '0;
        end
        p1_new_reg     <= (int'(cnt_reg) >= TAP_COUNT);
        p1_written_reg <= tap_written;
        p1_gain_reg    <= tap_gain;
        p2_new_reg     <= p1_new_reg;
        prod_reg       <= TPROD_W'(rd_sample) * TPROD_W'(p1_gain_reg);
        if (p2_valid_reg)
        begin
            if (p2_new_reg)
            begin
                acc_new_reg <= acc_new_reg + SUM_W'(prod_reg);
            end
            else
            begin
                acc_old_reg <= acc_old_reg + SUM_W'(prod_reg);
            end
        end
        if (state_reg == S_PUSH && out_free)
        begin
            send_reg        <= mix_res.send;
            blend_level_reg <= used_reg;
            fade_done_reg   <= (blend_reg == BLEND_ONE);
        end
    end

    assign out_valid   = out_valid_reg;
    assign send        = send_reg;
    assign blend_level = blend_level_reg;
    assign fade_done   = fade_done_reg;

    // The ring is written once, in the cycle after a beat is taken.
    a_write_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> $past(in_valid && !in_stall))
        else $error("ring write without an accepted beat");

    // The blend never climbs past one.
    a_blend_range: assert property (@(posedge clk) disable iff (!rst_n)
        blend_reg <= BLEND_ONE)
        else $error("blend beyond its limit");

    // Tap products only flow while taps are read or drained.
    a_pipe_state: assert property (@(posedge clk) disable iff (!rst_n)
        p2_valid_reg |-> (state_reg == S_READ || state_reg == S_DRAIN))
        else $error("tap product outside the read phase");

    // The crossfade starts only once both sums are complete.
    a_mix_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        mix_req.start |-> !p1_valid_reg && !p2_valid_reg)
        else $error("crossfade started with taps in flight");

endmodule

// ===== test/multitap_delay_send_crossfade_unit_tb.sv =====
// Self-checking testbench for the multi-tap delay send with crossfade.
// Depends on mtdxf_pkg and multitap_delay_send_crossfade_unit; a scoreboard class
// predicts each send beat from its own copy of the ring, taps and blend.
`timescale 1ns / 1ps

module multitap_delay_send_crossfade_unit_tb;

    import mtdxf_pkg::*;

    localparam int TAPS          = TAP_COUNT_DEF;
    localparam int REG_COUNT     = 2 * TAPS;
    localparam int OLD_TAP_BASE  = 0;
    localparam int NEW_TAP_BASE  = TAPS;
    localparam int CFG_INDEX_TOP = 2 ** CFG_INDEX_W - 1;

    localparam longint CYCLE_LIMIT = 4_000_000;
    localparam longint ROUND_HALF  = longint'(1) <<< (ROUND_SHIFT - 1);

    // Random phases, then one longer fade with extreme taps.
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 110;
    localparam int SWEEP_ITEMS = 120;

    // Tap programming styles for the random phases.
    localparam int TAPS_RANDOM  = 0;
    localparam int TAPS_EXTREME = 1;
    localparam int TAPS_SHORT   = 2;

    localparam logic [GAIN_W-1:0]  GAIN_MAX       = 16'h7FFF;
    localparam logic [GAIN_W-1:0]  GAIN_MIN       = 16'h8000;
    localparam logic [GAIN_W-1:0]  GAIN_UNITY     = 16'h4000;
    localparam logic [GAIN_W-1:0]  GAIN_NEG_UNITY = 16'hC000;
    localparam logic [DELAY_W-1:0] DELAY_MAX      = '1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sd32768;

    typedef struct {
        logic signed [SEND_W-1:0] send;
        logic [BLEND_W-1:0]       level;
        logic                     done;
    } send_beat_t;

    // Predicts the send beat for every accepted sample and checks the beats that come out.
    class crossfade_scoreboard;
        logic signed [SAMPLE_W-1:0] history [RING_LENGTH_DEF];
        logic [CFG_DATA_W-1:0]      taps [REG_COUNT];
        logic [DELAY_W-1:0]         wr_ptr;
        logic [BLEND_W-1:0]         fade_pos;
        send_beat_t                 awaited [$];
        int                         failures;
        int                         inputs;
        int                         checked;
        int                         writes;
        int                         done_seen;

        function new();
            foreach (history[i])
                history[i] = '0;
            foreach (taps[i])
                taps[i] = '0;
            wr_ptr    = '0;
            fade_pos  = '0;
            failures  = 0;
            inputs    = 0;
            checked   = 0;
            writes    = 0;
            done_seen = 0;
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= 10)
                $display("%s", msg);
        endfunction

        // Indexes past the tap registers are dropped by the block.
        function void write_reg(int idx, logic [CFG_DATA_W-1:0] data);
            writes++;
            if (idx < REG_COUNT)
                taps[idx] = data;
        endfunction

        // Exact Q5.29 sum of one tap set read back from the ring.
        function longint tap_sum(int base);
            longint                     acc;
            logic [DELAY_W-1:0]         pos;
            logic signed [GAIN_W-1:0]   gain;
            acc = 0;
            for (int t = 0; t < TAPS; t++)
            begin
                pos  = wr_ptr - taps[base + t][DELAY_W-1:0];
                gain = taps[base + t][GAIN_LSB +: GAIN_W];
                acc += longint'(history[pos]) * longint'(gain);
            end
            return acc;
        endfunction

        function void note_input(logic signed [SAMPLE_W-1:0] s, logic on, logic restart);
            longint             cur;
            longint             nxt;
            longint             mix;
            longint             rounded;
            logic [BLEND_W-1:0] used;
            send_beat_t         beat;
            inputs++;
            history[wr_ptr] = s;

            // Restart clears the blend first; a running fade then steps it up to one.
            if (restart)
                fade_pos = '0;
            if (on && fade_pos < BLEND_ONE)
                fade_pos++;
            used = on ? fade_pos : '0;

            // Crossfade, round half up, saturate to the send width.
            cur     = tap_sum(OLD_TAP_BASE);
            nxt     = on ? tap_sum(NEW_TAP_BASE) : 0;
            mix     = (cur <<< BLEND_SHIFT) + (nxt - cur) * longint'(used);
            rounded = (mix + ROUND_HALF) >>> ROUND_SHIFT;
            if (rounded > SEND_MAX)
                rounded = SEND_MAX;
            if (rounded < SEND_MIN)
                rounded = SEND_MIN;

            beat.send  = SEND_W'(rounded);
            beat.level = used;
            beat.done  = (fade_pos == BLEND_ONE);
            awaited.push_back(beat);
            wr_ptr++;
        endfunction

        function void check_result(send_beat_t got);
            send_beat_t want;
            checked++;
            if (got.done === 1'b1)
                done_seen++;
            if (awaited.size() == 0)
            begin
                report($sformatf("send beat %0d arrived with none expected: send %0d level %0d done %0b",
                                 checked, got.send, got.level, got.done));
                return;
            end
            want = awaited.pop_front();
            if (got.send !== want.send || got.level !== want.level || got.done !== want.done)
                report($sformatf({"send beat %0d mismatch: expected send %0d level %0d done %0b, ",
                                  "got send %0d level %0d done %0b"},
                                 checked, want.send, want.level, want.done,
                                 got.send, got.level, got.done));
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         in_valid     = 1'b0;
    logic                         in_stall;
    logic signed [SAMPLE_W-1:0]   sample       = '0;
    logic                         fade_on      = 1'b0;
    logic                         fade_restart = 1'b0;
    logic                         out_valid;
    logic                         out_stall    = 1'b0;
    logic signed [SEND_W-1:0]     send;
    logic [BLEND_W-1:0]           blend_level;
    logic                         fade_done;
    logic                         cfg_valid    = 1'b0;
    logic                         cfg_ready;
    logic [CFG_INDEX_W-1:0]       cfg_index    = '0;
    logic [CFG_DATA_W-1:0]        cfg_data     = '0;

    crossfade_scoreboard sb;
    bit                  steady_phase = 1'b0;
    longint              cycles       = 0;

    multitap_delay_send_crossfade_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .fade_on      (fade_on),
        .fade_restart (fade_restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .send         (send),
        .blend_level  (blend_level),
        .fade_done    (fade_done),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("multitap_delay_send_crossfade_unit test failed");
            $finish;
        end
    end

    // Every send beat taken from the block is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{send, blend_level, fade_done});
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 20);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 15))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_tap(int style);
        logic [GAIN_W-1:0]  gain;
        logic [DELAY_W-1:0] delay;
        gain  = GAIN_W'($urandom);
        delay = DELAY_W'($urandom);
        if (style == TAPS_EXTREME)
        begin
            case ($urandom_range(0, 4))
                0:       gain = GAIN_MAX;
                1:       gain = GAIN_MIN;
                2:       gain = GAIN_UNITY;
                3:       gain = GAIN_NEG_UNITY;
                default: gain = '0;
            endcase
            case ($urandom_range(0, 3))
                0:       delay = '0;
                1:       delay = DELAY_W'(1);
                2:       delay = DELAY_MAX;
                default: delay = DELAY_W'($urandom);
            endcase
        end
        else if (style == TAPS_SHORT)
            delay = DELAY_W'($urandom_range(0, 15));
        return {gain, delay};
    endfunction

    // Output stall: random runs of stall and release, held low in steady phases.
    initial
    begin
        int hold;
        bit stalled;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (steady_phase)
                out_stall <= 1'b0;
            else if (hold > 0)
                hold--;
            else
            begin
                stalled = ($urandom_range(0, 2) == 0);
                out_stall <= stalled;
                hold = stalled ? idle_len() : $urandom_range(0, 6);
            end
        end
    end

    task automatic write_tap_reg(int idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_INDEX_W'(idx);
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // Writes all tap registers plus a stray index or two that must be ignored.
    task automatic load_taps(int style);
        for (int i = 0; i < REG_COUNT; i++)
            write_tap_reg(i, pick_tap(style));
        repeat ($urandom_range(1, 2))
            write_tap_reg($urandom_range(REG_COUNT, CFG_INDEX_TOP), CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic set_all_taps(logic [CFG_DATA_W-1:0] value);
        for (int i = 0; i < REG_COUNT; i++)
            write_tap_reg(i, value);
        cfg_valid <= 1'b0;
    endtask

    // One sample beat; valid stays high into the next beat unless a gap follows.
    task automatic drive_sample(logic signed [SAMPLE_W-1:0] s, logic on, logic restart);
        int gap;
        in_valid     <= 1'b1;
        sample       <= s;
        fade_on      <= on;
        fade_restart <= restart;
        do @(posedge clk); while (in_stall);
        sb.note_input(s, on, restart);
        gap = steady_phase ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        bit noise;
        bit on;
        bit restart;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Mixed taps: delay zero, delay at the ring end, unity and extreme gains.
        write_tap_reg(OLD_TAP_BASE + 0, {GAIN_UNITY, DELAY_W'(0)});
        write_tap_reg(OLD_TAP_BASE + 1, {GAIN_MAX, DELAY_W'(1)});
        write_tap_reg(OLD_TAP_BASE + 2, {GAIN_MIN, DELAY_MAX});
        write_tap_reg(OLD_TAP_BASE + 3, {GAIN_NEG_UNITY, DELAY_W'(2)});
        write_tap_reg(NEW_TAP_BASE + 0, {GAIN_MAX, DELAY_W'(0)});
        write_tap_reg(NEW_TAP_BASE + 1, {GAIN_NEG_UNITY, DELAY_W'(3)});
        write_tap_reg(NEW_TAP_BASE + 2, '1);
        write_tap_reg(NEW_TAP_BASE + 3, {GAIN_UNITY, DELAY_MAX});
        write_tap_reg(REG_COUNT, '1);
        write_tap_reg(CFG_INDEX_TOP, '1);
        cfg_valid <= 1'b0;

        // Fade off, fade start, hold with fade off, restart while the fade is off.
        drive_sample(SAMPLE_MAX, 1'b0, 1'b0);
        drive_sample(SAMPLE_MIN, 1'b0, 1'b0);
        drive_sample(SAMPLE_MAX, 1'b1, 1'b1);
        drive_sample(SAMPLE_MIN, 1'b1, 1'b0);
        drive_sample('0, 1'b1, 1'b0);
        drive_sample(-16'sd1, 1'b1, 1'b0);
        drive_sample(16'sd1, 1'b0, 1'b0);
        drive_sample(SAMPLE_MAX, 1'b0, 1'b1);
        drive_sample(SAMPLE_MIN, 1'b1, 1'b0);
        drive_sample(SAMPLE_MAX, 1'b1, 1'b1);
        drive_sample(SAMPLE_MAX, 1'b1, 1'b1);
        drive_sample(16'sd1234, 1'b0, 1'b0);
        in_valid <= 1'b0;
        wait_idle();

        // Full-scale gains on every tap drive the send into both saturation limits.
        set_all_taps({GAIN_MAX, DELAY_W'(0)});
        drive_sample(SAMPLE_MAX, 1'b0, 1'b0);
        drive_sample(SAMPLE_MIN, 1'b0, 1'b0);
        drive_sample(SAMPLE_MAX, 1'b1, 1'b0);
        drive_sample(SAMPLE_MIN, 1'b1, 1'b0);
        in_valid <= 1'b0;
        wait_idle();
        set_all_taps({GAIN_MIN, DELAY_W'(0)});
        drive_sample(SAMPLE_MAX, 1'b0, 1'b0);
        drive_sample(SAMPLE_MIN, 1'b0, 1'b0);
        drive_sample(SAMPLE_MIN, 1'b1, 1'b1);
        drive_sample(SAMPLE_MAX, 1'b1, 1'b0);
        in_valid <= 1'b0;
        wait_idle();

        // Random phases: mostly running fades with rare restarts, some noise.
        for (int p = 0; p < PHASES; p++)
        begin
            load_taps(p % 3);
            steady_phase = (p == 3);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                noise = ($urandom_range(0, 9) == 0);
                if (noise)
                begin
                    on      = $urandom_range(0, 1);
                    restart = $urandom_range(0, 1);
                end
                else
                begin
                    on      = ($urandom_range(0, 7) != 0);
                    restart = ($urandom_range(0, 29) == 0);
                end
                drive_sample(pick_sample(), on, restart);
            end
            in_valid <= 1'b0;
            wait_idle();
        end

        // One longer fade from a restart, with the fade mostly running.
        load_taps(TAPS_EXTREME);
        steady_phase = 1'b0;
        for (int i = 0; i < SWEEP_ITEMS; i++)
        begin
            on      = ($urandom_range(0, 19) != 0);
            restart = (i == 0) || ($urandom_range(0, 59) == 0);
            drive_sample(pick_sample(), on, restart);
        end
        in_valid <= 1'b0;

        wait_idle();
        repeat (30) @(posedge clk);

        $display("Run covered %0d samples and %0d register writes; %0d send beats checked.",
                 sb.inputs, sb.writes, sb.checked);
        $display("%0d beats showed a finished fade; %0d failures.", sb.done_seen, sb.failures);
        if (sb.failures == 0)
            $display("multitap_delay_send_crossfade_unit test passed");
        else
            $display("multitap_delay_send_crossfade_unit test failed");
        $finish;
    end

endmodule

// ===== multitap_delay_send_crossfade_unit.f =====
rtl/core/mtdxf_pkg.sv
rtl/core/mtdxf_ram.sv
rtl/core/mtdxf_tap_addr.sv
rtl/core/mtdxf_mix.sv
rtl/core/multitap_delay_send_crossfade_unit.sv
test/multitap_delay_send_crossfade_unit_tb.sv
